// File: rtl/core/mxp3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mxp3_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam int PIX_W = 32;
    localparam int COORD_W = 12;
    localparam int NUM_SLOTS = 4;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    // result slots in emit order
    localparam int SLOT_UP_PREV  = 0;
    localparam int SLOT_LO_PREV  = 1;
    localparam int SLOT_UP_CUR   = 2;
    localparam int SLOT_LO_CUR   = 3;

    typedef logic [NUM_SLOTS-1:0] slot_mask_t;

    // coordinates and pending results of one pixel
    typedef struct packed {
        slot_mask_t         mask;
        logic [COORD_W-1:0] row_up;
        logic [COORD_W-1:0] row_cur;
        logic [COORD_W-1:0] col_prev;
        logic [COORD_W-1:0] col_cur;
    } pool_item_t;

    typedef struct packed {
        logic       has_up;
        logic       two_up;
        logic       first_col;
        pool_item_t item;
    } pix_ctl_t;

    // ieee total order key, -0 below +0
    function automatic logic [PIX_W-1:0] order_key(input logic [PIX_W-1:0] x);
        order_key = x[PIX_W-1] ? ~x : (x | {1'b1, {(PIX_W-1){1'b0}}});
    endfunction

    function automatic logic [PIX_W-1:0] fmax_bits(input logic [PIX_W-1:0] a,
                                                   input logic [PIX_W-1:0] b);
        fmax_bits = (order_key(a) >= order_key(b)) ? a : b;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/mxp3_pix_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mxp3_pix_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink (input valid, input pixel_value, output ready);
endinterface

`default_nettype wire

// File: rtl/core/mxp3_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mxp3_res_if;
    logic        valid;
    logic        ready;
    logic [11:0] out_row;
    logic [11:0] out_col;
    logic [31:0] max_value;
    logic        run_last;

    modport source (output valid, output out_row, output out_col, output max_value,
                    output run_last, input ready);
    modport sink (input valid, input out_row, input out_col, input max_value,
                  input run_last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/mxp3_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mxp3_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [12:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/max_pool_3x3_stride1_same.sv
`timescale 1ns / 1ps
`default_nettype none

// streaming 3x3 max pooling, stride 1, same-size output, clipped borders
// pixel_in: one ieee single-precision pixel per beat, raster order
// result_out: one pooled pixel per beat with its row and column; run_last
//   marks the final beat caused by one input pixel
// cfg: register 0 image_width, register 1 image_height; a write restarts
//   the frame at row 0, column 0; write only while the block is idle
// output row r-1 streams out while row r streams in, one column behind;
//   during the last row each column of the row above is followed by the
//   same column of the last row
// pipeline: the line stage register, then the emit stage register and the windows, then the output register
// throughput: one pixel per cycle while the receiver keeps up; a pixel with more than one result holds
//   the input until the single output register has taken them all (two beats at
//   row ends and through the last row, four on the last pixel of a frame)
// line buffers are two single-port-read rams, MAX_WIDTH words each; a
//   same-column read right after a write is forwarded from the pipeline
// reset: counters to 0, windows cleared, size 640 x 480; the line rams
//   need no clearing since row 0 only writes them
// a stalled receiver holds the output register and backs up into the
//   pipeline and then pixel_in.ready
module max_pool_3x3_stride1_same
    import mxp3_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    mxp3_cfg_if.sink   cfg,
    mxp3_pix_if.sink   pixel_in,
    mxp3_res_if.source result_out
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int WW   = $clog2(MAX_WIDTH) + 1;
    localparam int HW   = $clog2(MAX_HEIGHT) + 1;
    localparam int WCMP = (WW > CFG_DATA_W) ? WW : CFG_DATA_W;
    localparam int HCMP = (HW > CFG_DATA_W) ? HW : CFG_DATA_W;

    logic [CFG_DATA_W-1:0] width_reg, height_reg;
    logic [CW-1:0]         col_reg, col_next;
    logic [RW-1:0]         row_reg, row_next;
    logic [WCMP-1:0]       width_ext, eff_w, w_last;
    logic [HCMP-1:0]       height_ext, eff_h, h_last;
    logic                  cfg_write, pix_accept, stage_ready;
    logic                  at_row_end, at_last_row, has_up;
    pix_ctl_t              ctl;
    logic                  item_valid, item_ready;
    pool_item_t            item;
    logic [PIX_W-1:0]      win_upper [3];
    logic [PIX_W-1:0]      win_lower [3];

    assign cfg.ready  = 1'b1;
    assign cfg_write  = cfg.valid;

    // clamp frame size to 1..max
    always_comb
    begin
        width_ext  = WCMP'(width_reg);
        height_ext = HCMP'(height_reg);
        if (width_ext == '0)
            eff_w = WCMP'(1);
        else if (width_ext > WCMP'(MAX_WIDTH))
            eff_w = WCMP'(MAX_WIDTH);
        else
            eff_w = width_ext;
        if (height_ext == '0)
            eff_h = HCMP'(1);
        else if (height_ext > HCMP'(MAX_HEIGHT))
            eff_h = HCMP'(MAX_HEIGHT);
        else
            eff_h = height_ext;
        w_last = eff_w - WCMP'(1);
        h_last = eff_h - HCMP'(1);
    end

    assign at_row_end  = (WCMP'(col_reg) == w_last);
    assign at_last_row = (HCMP'(row_reg) == h_last);
    assign has_up      = (row_reg != '0);

    // which results this pixel causes
    always_comb
    begin
        ctl.has_up                   = has_up;
        ctl.two_up                   = (row_reg > RW'(1));
        ctl.first_col                = (col_reg == '0);
        ctl.item.mask[SLOT_UP_PREV]  = (col_reg != '0) && has_up;
        ctl.item.mask[SLOT_LO_PREV]  = (col_reg != '0) && at_last_row;
        ctl.item.mask[SLOT_UP_CUR]   = at_row_end && has_up;
        ctl.item.mask[SLOT_LO_CUR]   = at_row_end && at_last_row;
        ctl.item.row_cur             = COORD_W'(row_reg);
        ctl.item.row_up              = COORD_W'(row_reg) - COORD_W'(1);
        ctl.item.col_cur             = COORD_W'(col_reg);
        ctl.item.col_prev            = COORD_W'(col_reg) - COORD_W'(1);
    end

    assign pixel_in.ready = stage_ready;
    assign pix_accept     = pixel_in.valid && stage_ready;

    // raster position of the next pixel
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (pix_accept)
        begin
            if (at_row_end)
            begin
                col_next = '0;
                row_next = at_last_row ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
        if (cfg_write)
        begin
            col_next = '0;
            row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_DATA_W'(640);
            height_reg <= CFG_DATA_W'(480);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (cfg_write)
            begin
                unique case (cfg.index)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg.data;
                    REG_IMAGE_HEIGHT: height_reg <= cfg.data;
                    default:          ;
                endcase
            end
        end
    end

    // line buffers, neighborhood maxima and column windows
    mxp3_line_stage #(.DEPTH(MAX_WIDTH)) u_line (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (pixel_in.valid),
        .in_ready   (stage_ready),
        .pixel      (pixel_in.pixel_value),
        .col        (col_reg),
        .ctl        (ctl),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .win_upper  (win_upper),
        .win_lower  (win_lower)
    );

    // serializes up to four results per pixel onto the output register
    mxp3_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .win_upper  (win_upper),
        .win_lower  (win_lower),
        .res        (result_out)
    );

endmodule

`default_nettype wire

// File: rtl/core/mxp3_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mxp3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/mxp3_line_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module mxp3_line_stage
    import mxp3_pkg::*;
#(
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [PIX_W-1:0]         pixel,
    input  wire logic [$clog2(DEPTH)-1:0] col,
    input  wire pix_ctl_t                 ctl,
    output logic                          item_valid,
    input  wire logic                     item_ready,
    output pool_item_t                    item,
    output logic      [PIX_W-1:0]         win_upper [3],
    output logic      [PIX_W-1:0]         win_lower [3]
);

    localparam int AW = $clog2(DEPTH);

    logic             s1_valid_reg, s1_valid_next;
    logic [PIX_W-1:0] s1_pix_reg;
    logic [AW-1:0]    s1_col_reg;
    pix_ctl_t         s1_ctl_reg;
    logic             fwd_reg;
    logic [PIX_W-1:0] fwd_newer_reg, fwd_older_reg;
    logic [PIX_W-1:0] ram_newer, ram_older;
    logic [PIX_W-1:0] nw, ol, lo, up;
    logic             accept, advance;

    assign advance  = s1_valid_reg && item_ready;
    assign in_ready = !s1_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    mxp3_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_newer (
        .clk   (clk),
        .we    (advance),
        .waddr (s1_col_reg),
        .wdata (s1_pix_reg),
        .re    (accept),
        .raddr (col),
        .rdata (ram_newer)
    );

    mxp3_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_older (
        .clk   (clk),
        .we    (advance && s1_ctl_reg.has_up),
        .waddr (s1_col_reg),
        .wdata (nw),
        .re    (accept),
        .raddr (col),
        .rdata (ram_older)
    );

    // same column back to back (one pixel wide frame): take the write in flight
    always_comb
    begin
        nw = fwd_reg ? fwd_newer_reg : ram_newer;
        ol = fwd_reg ? fwd_older_reg : ram_older;
        lo = s1_ctl_reg.has_up ? fmax_bits(nw, s1_pix_reg) : s1_pix_reg;
        up = s1_ctl_reg.two_up ? fmax_bits(lo, ol) : lo;
    end

    assign s1_valid_next = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                win_upper[i] <= '0;
                win_lower[i] <= '0;
            end
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (advance)
            begin
                if (s1_ctl_reg.first_col)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        win_upper[i] <= up;
                        win_lower[i] <= lo;
                    end
                end
                else
                begin
                    win_upper[0] <= win_upper[1];
                    win_upper[1] <= win_upper[2];
                    win_upper[2] <= up;
                    win_lower[0] <= win_lower[1];
                    win_lower[1] <= win_lower[2];
                    win_lower[2] <= lo;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg    <= pixel;
            s1_col_reg    <= col;
            s1_ctl_reg    <= ctl;
            fwd_reg       <= s1_valid_reg && (s1_col_reg == col);
            fwd_newer_reg <= s1_pix_reg;
            fwd_older_reg <= s1_ctl_reg.has_up ? nw : ol;
        end
    end

    assign item_valid = s1_valid_reg;
    assign item       = s1_ctl_reg.item;

endmodule

`default_nettype wire

// File: rtl/core/mxp3_emit.sv
`timescale 1ns / 1ps
`default_nettype none

module mxp3_emit
    import mxp3_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire pool_item_t       item,
    input  wire logic [PIX_W-1:0] win_upper [3],
    input  wire logic [PIX_W-1:0] win_lower [3],
    mxp3_res_if.source            res
);

    logic               s2_valid_reg, s2_valid_next;
    pool_item_t         s2_item_reg;
    slot_mask_t         mask_reg, mask_next, pick, rest;
    logic               out_valid_reg, out_valid_next;
    logic [COORD_W-1:0] row_reg, col_reg;
    logic [PIX_W-1:0]   val_reg;
    logic               last_reg;
    logic [COORD_W-1:0] sel_row, sel_col;
    logic [PIX_W-1:0]   sel_val;
    logic               out_free, fire, done, load;

    assign pick = mask_reg & (~mask_reg + slot_mask_t'(1));
    assign rest = mask_reg & ~pick;

    assign out_free   = !out_valid_reg || res.ready;
    assign fire       = s2_valid_reg && (mask_reg != '0) && out_free;
    assign done       = s2_valid_reg && ((mask_reg == '0) || (fire && (rest == '0)));
    assign item_ready = !s2_valid_reg || done;
    assign load       = item_valid && item_ready;

    always_comb
    begin
        sel_row = s2_item_reg.row_up;
        sel_col = s2_item_reg.col_prev;
        sel_val = fmax_bits(fmax_bits(win_upper[0], win_upper[1]), win_upper[2]);
        case (1'b1)
            pick[SLOT_LO_PREV]:
            begin
                sel_row = s2_item_reg.row_cur;
                sel_val = fmax_bits(fmax_bits(win_lower[0], win_lower[1]), win_lower[2]);
            end
            pick[SLOT_UP_CUR]:
            begin
                sel_col = s2_item_reg.col_cur;
                sel_val = fmax_bits(win_upper[1], win_upper[2]);
            end
            pick[SLOT_LO_CUR]:
            begin
                sel_row = s2_item_reg.row_cur;
                sel_col = s2_item_reg.col_cur;
                sel_val = fmax_bits(win_lower[1], win_lower[2]);
            end
            default:
            begin
                sel_row = s2_item_reg.row_up;
            end
        endcase
    end

    always_comb
    begin
        s2_valid_next  = load ? 1'b1 : (done ? 1'b0 : s2_valid_reg);
        mask_next      = load ? item.mask : (fire ? rest : mask_reg);
        out_valid_next = fire || (out_valid_reg && !res.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s2_item_reg <= item;
        end
        if (fire)
        begin
            row_reg  <= sel_row;
            col_reg  <= sel_col;
            val_reg  <= sel_val;
            last_reg <= (rest == '0);
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.out_row   = row_reg;
    assign res.out_col   = col_reg;
    assign res.max_value = val_reg;
    assign res.run_last  = last_reg;

endmodule

`default_nettype wire
